// ===== rtl/core/rope_angle_generator_defines.svh =====
// Assertion macros for the checker file of the rotary angle generator.
`ifndef ROPE_ANGLE_GENERATOR_DEFINES_SVH
`define ROPE_ANGLE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RAG_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAG_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rag_pkg.sv =====
// Types, constants and elaboration-time functions of the rotary angle generator.
`timescale 1ns / 1ps
`default_nettype none

package rag_pkg;

  localparam int ROT_DIM       = 128;
  localparam int HALF_DIM      = ROT_DIM / 2;
  localparam int POSITION_BITS = 20;

  localparam int DIM_W     = 7;
  localparam int KW        = DIM_W - 1;
  localparam int POS_W     = POSITION_BITS;
  localparam int ANGLE_W   = 40;
  localparam int FRAC_W    = 32;
  localparam int LOG_INT_W = 5;
  localparam int LOG_W     = LOG_INT_W + FRAC_W;
  localparam int THETA_W   = FRAC_W + 1;
  localparam int COEF_W    = FRAC_W;
  localparam int Q16       = 16;
  localparam int DIV_W     = THETA_W + Q16;
  localparam int DVS_W     = 24;
  localparam int RAMP_W    = 17;
  localparam int RNUM_W    = 16;
  localparam int RDEN_W    = 17;
  localparam int RN_W      = 18;
  localparam int BL_W      = RAMP_W + ANGLE_W;
  localparam int PROD_W    = POS_W + ANGLE_W;
  localparam int BETA_FRAC = 8;

  localparam int EXP_STAGES = FRAC_W;
  localparam int NSTG       = EXP_STAGES + DIV_W + 6;
  localparam int ST_OUT     = NSTG - 1;

  localparam int MODE_W     = 2;
  localparam int BASE_W     = 32;
  localparam int SCALE_W    = 24;
  localparam int BETA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_YARN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_DIV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_DIV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_FAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_SLOW  = 3'd5;

  localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd2560000;
  localparam logic [BASE_W-1:0]  BASE_ONE    = 32'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [BETA_W-1:0]  FAST_RESET  = 16'd8192;
  localparam logic [BETA_W-1:0]  SLOW_RESET  = 16'd256;

  localparam logic [THETA_W-1:0] THETA_ONE = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [RAMP_W-1:0]  RAMP_ONE  = {1'b1, {Q16{1'b0}}};
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = {ANGLE_W{1'b1}};

  typedef struct packed {
    logic [LOG_W-1:0]  e;
    logic [POS_W-1:0]  pos;
    logic [RNUM_W-1:0] rnum;
    logic [RDEN_W-1:0] rden;
    logic              rdiv;
    logic [RAMP_W-1:0] rconst;
  } exp_side_t;

  typedef struct packed {
    logic [THETA_W-1:0] theta;
    logic [POS_W-1:0]   pos;
    logic               rdiv;
    logic [RAMP_W-1:0]  rconst;
  } div_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Factor 2^(-2^-i) in Q.32, built by repeated square roots.
  function automatic logic [COEF_W-1:0] exp_coef(input int i);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 2; j <= i; j++) begin
      c = isqrt64(c << 32);
    end
    return c[COEF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rag_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface rag_in_if import rag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] dim;
  logic [POS_W-1:0] position;
  modport source (output valid, dim, position, input ready);
  modport sink (input valid, dim, position, output ready);
endinterface

interface rag_out_if import rag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic               saturated;
  modport source (output valid, angle, saturated, input ready);
  modport sink (input valid, angle, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rag_log2.sv =====
// Sequential log2 unit for the frequency base, one squaring per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rag_log2 import rag_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [BASE_W-1:0] base,
  output logic                   busy,
  output logic [LOG_W-1:0]       log2_val
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_NORM, S_SQ} state_t;

  state_t                 state;
  logic [BASE_W-1:0]      m;
  logic [LOG_INT_W-1:0]   msb;
  logic [FRAC_W-1:0]      frac;
  logic [LOG_INT_W-1:0]   cnt;
  logic [2*BASE_W-1:0]    sq;
  logic [BASE_W:0]        t;

  assign sq   = (2*BASE_W)'(m) * (2*BASE_W)'(m);
  assign t    = sq[2*BASE_W-1:BASE_W-1];
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else if (start) begin
      state <= S_LOAD;
    end else begin
      unique case (state)
        S_LOAD: begin
          m     <= (base < BASE_ONE) ? BASE_ONE : base;
          msb   <= '1;
          state <= S_NORM;
        end
        S_NORM: begin
          if (m[BASE_W-1]) begin
            cnt   <= '0;
            frac  <= '0;
            state <= S_SQ;
          end else begin
            m   <= m << 1;
            msb <= msb - LOG_INT_W'(1);
          end
        end
        S_SQ: begin
          frac <= {frac[FRAC_W-2:0], t[BASE_W]};
          m    <= t[BASE_W] ? t[BASE_W:1] : t[BASE_W-1:0];
          cnt  <= cnt + LOG_INT_W'(1);
          if (cnt == '1) begin
            log2_val <= {msb - LOG_INT_W'(BETA_FRAC), frac[FRAC_W-2:0], t[BASE_W]};
            state    <= S_IDLE;
          end
        end
        S_IDLE: begin
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rag_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rag_div import rag_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient
);

  logic [DVS_W-1:0] rem      [0:DIV_W-1];
  logic [DIV_W-1:0] dvd      [0:DIV_W-1];
  logic [DIV_W-1:0] quo      [0:DIV_W-1];
  logic [DVS_W-1:0] dvs      [0:DIV_W-1];
  logic [DVS_W-1:0] rem_next [0:DIV_W-1];
  logic [DIV_W-1:0] dvd_next [0:DIV_W-1];
  logic [DIV_W-1:0] quo_next [0:DIV_W-1];
  logic [DVS_W-1:0] dvs_next [0:DIV_W-1];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic [DVS_W-1:0] rem_in;
    logic [DIV_W-1:0] dvd_in;
    logic [DIV_W-1:0] quo_in;
    logic [DVS_W-1:0] dvs_in;
    logic [DVS_W:0]   trial;
    logic             ge;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend;
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_rest
      assign rem_in = rem[s-1];
      assign dvd_in = dvd[s-1];
      assign quo_in = quo[s-1];
      assign dvs_in = dvs[s-1];
    end
    assign trial       = {rem_in, dvd_in[DIV_W-1]};
    assign ge          = (trial >= {1'b0, dvs_in});
    assign rem_next[s] = ge ? DVS_W'(trial - {1'b0, dvs_in}) : trial[DVS_W-1:0];
    assign dvd_next[s] = dvd_in << 1;
    assign quo_next[s] = {quo_in[DIV_W-2:0], ge};
    assign dvs_next[s] = dvs_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_W; s++) begin
        rem[s] <= rem_next[s];
        dvd[s] <= dvd_next[s];
        quo[s] <= quo_next[s];
        dvs[s] <= dvs_next[s];
      end
    end
  end

  assign quotient = quo[DIV_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/rope_angle_generator.sv =====
// Top level of the rotary position embedding angle generator.
//
// Input channel item_in carries a dimension index and a token position; the
// result channel item_out carries the Q24.16 angle and a saturation flag, one
// result per item, in order. Both channels use valid/ready.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data only while no item is in flight, a user rule the block does not check.
// The block is a pipeline of 87 stages, and a new item can be accepted every
// cycle while the pipeline is not held and the log2 unit is idle. The depth
// includes 32 exponent multiply stages and a 49-stage divider.
// After reset, and after every write to the base register, the log2 unit
// recomputes the base logarithm one squaring per cycle; input ready stays low
// while it runs.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds; items behind it stay in place and nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module rope_angle_generator import rag_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rag_in_if.sink                     item_in,
  rag_out_if.source                  item_out,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0]        scale_mode;
  logic [BASE_W-1:0]        rot_base;
  logic [SCALE_W-1:0]       lin_div;
  logic [SCALE_W-1:0]       interp_div;
  logic signed [BETA_W-1:0] beta_fast;
  logic signed [BETA_W-1:0] beta_slow;

  logic [NSTG-1:0]   vld;
  logic              adv;
  logic              acc;
  logic              busy;
  logic [LOG_W-1:0]  log2_val;
  logic              base_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode <= MODE_NONE;
      rot_base   <= BASE_RESET;
      lin_div    <= SCALE_RESET;
      interp_div <= SCALE_RESET;
      beta_fast  <= FAST_RESET;
      beta_slow  <= SLOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE_MODE: scale_mode <= cfg_data[MODE_W-1:0];
        REG_ROT_BASE:   rot_base   <= cfg_data[BASE_W-1:0];
        REG_LIN_DIV:    lin_div    <= cfg_data[SCALE_W-1:0];
        REG_INTERP_DIV: interp_div <= cfg_data[SCALE_W-1:0];
        REG_BETA_FAST:  beta_fast  <= cfg_data[BETA_W-1:0];
        REG_BETA_SLOW:  beta_slow  <= cfg_data[BETA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign base_start = cfg_write && (cfg_index == REG_ROT_BASE);

  rag_log2 u_log2 (
    .clk      (clk),
    .rst      (rst),
    .start    (base_start),
    .base     (rot_base),
    .busy     (busy),
    .log2_val (log2_val)
  );

  assign adv           = !vld[ST_OUT] || item_out.ready;
  assign item_in.ready = adv && !busy;
  assign acc           = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], acc};
    end
  end

  // Entry stage: exponent and ramp operands.
  logic [LOG_W+KW-1:0]   ek;
  logic signed [RN_W-1:0] num_s;
  logic signed [RN_W-1:0] den_s;
  logic signed [RN_W-1:0] num_a;
  logic signed [RN_W-1:0] den_a;
  logic                   num_pos;
  exp_side_t              s0_side;

  assign ek      = (LOG_W+KW)'(log2_val) * (LOG_W+KW)'(item_in.dim[DIM_W-1:1]);
  assign num_s   = $signed(RN_W'({item_in.dim, BETA_FRAC'(0)})) - RN_W'(beta_slow);
  assign den_s   = RN_W'(beta_fast) - RN_W'(beta_slow) + RN_W'(1);
  assign num_a   = den_s[RN_W-1] ? -num_s : num_s;
  assign den_a   = den_s[RN_W-1] ? -den_s : den_s;
  assign num_pos = !num_a[RN_W-1] && (num_a != '0);

  always_comb begin
    s0_side        = '0;
    s0_side.e      = LOG_W'(ek / HALF_DIM);
    s0_side.pos    = item_in.position;
    priority if (den_a == '0) begin
      s0_side.rconst = num_pos ? RAMP_ONE : '0;
    end else if (!num_pos) begin
      s0_side.rconst = '0;
    end else if (num_a >= den_a) begin
      s0_side.rconst = RAMP_ONE;
    end else begin
      s0_side.rdiv = 1'b1;
      s0_side.rnum = num_a[RNUM_W-1:0];
      s0_side.rden = den_a[RDEN_W-1:0];
    end
  end

  // Exponent stages: one conditional multiply per fraction bit.
  exp_side_t          ex_side   [0:EXP_STAGES];
  logic [THETA_W-1:0] ex_r      [1:EXP_STAGES];
  logic [THETA_W-1:0] ex_r_next [1:EXP_STAGES];

  for (genvar g = 1; g <= EXP_STAGES; g++) begin : g_exp
    localparam logic [COEF_W-1:0] COEF = exp_coef(g);
    logic [THETA_W-1:0]        r_in;
    logic [THETA_W+COEF_W-1:0] prod;
    if (g == 1) begin : g_first
      assign r_in = THETA_ONE;
    end else begin : g_rest
      assign r_in = ex_r[g-1];
    end
    assign prod = (THETA_W+COEF_W)'(r_in) * (THETA_W+COEF_W)'(COEF);
    assign ex_r_next[g] = ex_side[g-1].e[FRAC_W-g] ? prod[THETA_W+COEF_W-1:COEF_W] : r_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_side[0] <= s0_side;
      for (int s = 1; s <= EXP_STAGES; s++) begin
        ex_side[s] <= ex_side[s-1];
        ex_r[s]    <= ex_r_next[s];
      end
    end
  end

  // Theta stage: integer shift of the exponent.
  div_side_t         th_side;
  logic [RNUM_W-1:0] th_rnum;
  logic [RDEN_W-1:0] th_rden;

  always_ff @(posedge clk) begin
    if (adv) begin
      th_side.theta  <= ex_r[EXP_STAGES] >> ex_side[EXP_STAGES].e[LOG_W-1:FRAC_W];
      th_side.pos    <= ex_side[EXP_STAGES].pos;
      th_side.rdiv   <= ex_side[EXP_STAGES].rdiv;
      th_side.rconst <= ex_side[EXP_STAGES].rconst;
      th_rnum        <= ex_side[EXP_STAGES].rnum;
      th_rden        <= ex_side[EXP_STAGES].rden;
    end
  end

  // Divider stages.
  logic [SCALE_W-1:0] dsel;
  logic [DVS_W-1:0]   dvs_main;
  logic [DIV_W-1:0]   q_main;
  logic [DIV_W-1:0]   q_ramp;
  div_side_t          dv_side [0:DIV_W-1];

  assign dsel     = (scale_mode == MODE_LINEAR) ? lin_div : interp_div;
  assign dvs_main = (dsel == '0) ? DVS_W'(1) : DVS_W'(dsel);

  rag_div u_div_theta (
    .clk      (clk),
    .en       (adv),
    .dividend ({th_side.theta, Q16'(0)}),
    .divisor  (dvs_main),
    .quotient (q_main)
  );

  rag_div u_div_ramp (
    .clk      (clk),
    .en       (adv),
    .dividend (DIV_W'({th_rnum, Q16'(0)})),
    .divisor  (DVS_W'(th_rden)),
    .quotient (q_ramp)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0] <= th_side;
      for (int s = 1; s < DIV_W; s++) begin
        dv_side[s] <= dv_side[s-1];
      end
    end
  end

  // Blend products.
  logic [ANGLE_W-1:0] yt;
  logic [RAMP_W-1:0]  rr;
  logic [BL_W-1:0]    p1_c;
  logic [BL_W-1:0]    p2_c;
  logic [BL_W-1:0]    bl_p1;
  logic [BL_W-1:0]    bl_p2;
  logic [ANGLE_W-1:0] bl_yt;
  logic [THETA_W-1:0] bl_theta;
  logic [POS_W-1:0]   bl_pos;

  assign yt   = (q_main[DIV_W-1:ANGLE_W] != '0) ? ANGLE_MAX : q_main[ANGLE_W-1:0];
  assign rr   = dv_side[DIV_W-1].rdiv ? q_ramp[RAMP_W-1:0] : dv_side[DIV_W-1].rconst;
  assign p1_c = BL_W'(RAMP_ONE - rr) * BL_W'(yt);
  assign p2_c = BL_W'(rr) * BL_W'(dv_side[DIV_W-1].theta);

  always_ff @(posedge clk) begin
    if (adv) begin
      bl_p1    <= p1_c;
      bl_p2    <= p2_c;
      bl_yt    <= yt;
      bl_theta <= dv_side[DIV_W-1].theta;
      bl_pos   <= dv_side[DIV_W-1].pos;
    end
  end

  // Mode selection.
  logic [BL_W:0]      bl_sum;
  logic [ANGLE_W-1:0] thf_c;
  logic [ANGLE_W-1:0] sl_thf;
  logic [POS_W-1:0]   sl_pos;

  assign bl_sum = (BL_W+1)'(bl_p1) + (BL_W+1)'(bl_p2);

  always_comb begin
    unique case (scale_mode)
      MODE_LINEAR: thf_c = bl_yt;
      MODE_YARN:   thf_c = bl_sum[ANGLE_W+Q16-1:Q16];
      default:     thf_c = ANGLE_W'(bl_theta);
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl_thf <= thf_c;
      sl_pos <= bl_pos;
    end
  end

  // Position multiply and output register.
  logic [PROD_W-1:0]  mu_prod;
  logic [ANGLE_W-1:0] ov_angle;
  logic               ov_sat;
  logic               sat_c;

  assign sat_c = (mu_prod[PROD_W-1:ANGLE_W+Q16] != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_prod  <= PROD_W'(sl_pos) * PROD_W'(sl_thf);
      ov_angle <= sat_c ? ANGLE_MAX : mu_prod[ANGLE_W+Q16-1:Q16];
      ov_sat   <= sat_c;
    end
  end

  assign item_out.valid     = vld[ST_OUT];
  assign item_out.angle     = ov_angle;
  assign item_out.saturated = ov_sat;

endmodule

`default_nettype wire

// ===== rtl/core/rag_checker.sv =====
// Port-level checker for the rotary angle generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rope_angle_generator_defines.svh"

module rag_checker import rag_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_ready,
  input wire logic                 cfg_write,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [ANGLE_W-1:0]   angle,
  input wire logic                 saturated
);

  logic             stalled;
  logic             base_wr;
  logic [ANGLE_W:0] out_word;

  assign stalled  = out_valid && !out_ready;
  assign base_wr  = cfg_write && (cfg_index == REG_ROT_BASE);
  assign out_word = {angle, saturated};

  `RAG_ASSERT_IMP(a_sat_full, clk, rst, out_valid && saturated, angle == ANGLE_MAX, "bad sat")
  `RAG_ASSERT_NEXT(a_out_hold, clk, rst, stalled, out_valid && $stable(out_word), "item moved")
  `RAG_ASSERT_NEXT(a_base_busy, clk, rst, base_wr, !in_ready, "ready during base log")
  `RAG_ASSERT_IMP(a_reset_busy, clk, rst, $fell(rst), !in_ready, "ready right after reset")

endmodule

bind rope_angle_generator rag_checker u_rag_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item_in.ready),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index),
  .out_valid (item_out.valid),
  .out_ready (item_out.ready),
  .angle     (item_out.angle),
  .saturated (item_out.saturated)
);

`default_nettype wire
